>>> hw/rtl/prct_pkg.sv
package prct_pkg;

    typedef enum logic [2:0] {
        MODE_ADD       = 3'd0,
        MODE_LOOKUP_HOPS = 3'd1,
        MODE_LOOKUP_NB = 3'd2,
        MODE_CLEAR     = 3'd3,
        MODE_CLEAR_OLD = 3'd4,
        MODE_REMOVE_NB = 3'd5
    } mode_t;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
    localparam int          MASK_WIDTH    = 16;

    typedef struct packed {
        logic [7:0]  nb;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  hops;
        logic [31:0] files;
        logic [31:0] volume;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic clr;       // zero scan pointers and result
        logic step;      // evaluate entry at scan pointer
        logic finish;    // commit result / counts
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;      // scan reached its end or hit, or the mode does not scan
    } stat_t;

endpackage

>>> hw/rtl/prct_ctrl.sv
module prct_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  prct_pkg::stat_t stat,
    output prct_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.clr    = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> hw/rtl/prct_dp.sv
module prct_dp
#(
    parameter int DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  prct_pkg::cmd_t  cmd,
    output prct_pkg::stat_t stat,
    input  logic [2:0]      mode,
    input  logic [7:0]      neighbour_id,
    input  logic [31:0]     address,
    input  logic [15:0]     port,
    input  logic [7:0]      hops,
    input  logic [31:0]     files,
    input  logic [31:0]     volume,
    input  logic [15:0]     ignore_mask,
    input  logic [31:0]     now_ms,
    input  logic [31:0]     timeout,
    output logic            done,
    output logic            found,
    output logic [3:0]      entry_index,
    output logic [7:0]      out_neighbour,
    output logic [31:0]     out_address,
    output logic [15:0]     out_port,
    output logic [7:0]      out_hops,
    output logic [31:0]     out_files,
    output logic [31:0]     out_volume,
    output logic            cleared,
    output logic            table_full
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    prct_pkg::entry_t mem [DEPTH];

    logic [CW-1:0] count_reg;
    logic [31:0]   clear_time_reg;
    logic [CW-1:0] rd_reg, wr_reg;       // scan read and compaction write pointers
    logic [CW-1:0] rd_next;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    prct_pkg::entry_t hit_ent_reg;

    // latched command word
    logic [2:0]  mode_reg;
    logic [7:0]  nb_reg;
    logic [31:0] addr_reg, files_reg, vol_reg, now_reg;
    logic [15:0] port_reg, mask_reg;
    logic [7:0]  hops_reg;

    logic done_reg, found_reg, cleared_reg, full_reg;
    logic [3:0] idx_reg;
    prct_pkg::entry_t out_reg;

    prct_pkg::entry_t cur_reg;           // entry at the scan pointer
    logic [IW-1:0] rd_idx;
    logic match, at_end, masked;
    logic scan_mode;
    logic aged;

    function automatic logic ignore_bit(input logic [15:0] m, input logic [CW-1:0] p);
        logic [CW+3:0] pw;
        pw = {4'd0, p};
        return m[pw[3:0]];
    endfunction

    assign rd_idx = rd_reg[IW-1:0];
    assign at_end = (rd_reg >= count_reg);
    assign masked = ({{(32-CW){1'b0}}, rd_reg} < 32'(prct_pkg::MASK_WIDTH))
                  && ignore_bit(mask_reg, rd_reg);

    always_comb
    begin
        if (cmd.clr)
            rd_next = '0;
        else if (cmd.step)
            rd_next = rd_reg + 1'b1;
        else
            rd_next = rd_reg;
    end

    always_comb
    begin
        unique case (mode_reg)
            prct_pkg::MODE_ADD:
                match = cur_reg.port == port_reg && cur_reg.hops == hops_reg
                     && cur_reg.addr == addr_reg;
            prct_pkg::MODE_LOOKUP_HOPS:
                match = cur_reg.hops == hops_reg && cur_reg.nb != nb_reg && !masked;
            prct_pkg::MODE_LOOKUP_NB:
                match = cur_reg.nb == nb_reg;
            default:
                match = 1'b0;
        endcase
    end

    assign scan_mode = mode_reg == prct_pkg::MODE_ADD || mode_reg == prct_pkg::MODE_LOOKUP_HOPS
                    || mode_reg == prct_pkg::MODE_LOOKUP_NB
                    || mode_reg == prct_pkg::MODE_REMOVE_NB;
    assign stat.done = !scan_mode || at_end || hit_reg;

    // scan and memory
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg  <= mode;      nb_reg   <= neighbour_id;
            addr_reg  <= address;   port_reg <= port;
            hops_reg  <= hops;      files_reg <= files;
            vol_reg   <= volume;    mask_reg <= ignore_mask;
            now_reg   <= now_ms;
        end
        rd_reg  <= rd_next;
        cur_reg <= mem[rd_next[IW-1:0]];
        if (cmd.clr)
        begin
            wr_reg  <= '0;
            hit_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (mode_reg == prct_pkg::MODE_REMOVE_NB)
            begin
                // compact: keep entries of other neighbours
                if (cur_reg.nb != nb_reg)
                begin
                    mem[wr_reg[IW-1:0]] <= cur_reg;
                    wr_reg <= wr_reg + 1'b1;
                end
            end
            else if (match)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_idx;
                hit_ent_reg <= cur_reg;
            end
        end
        else if (cmd.finish && mode_reg == prct_pkg::MODE_ADD)
        begin
            if (hit_reg)
            begin
                mem[hit_idx_reg] <= '{hit_ent_reg.nb, hit_ent_reg.addr, hit_ent_reg.port,
                                      hit_ent_reg.hops, files_reg, vol_reg};
            end
            else if (count_reg < CW'(DEPTH))
            begin
                mem[count_reg[IW-1:0]] <= '{nb_reg, addr_reg, port_reg, hops_reg,
                                            files_reg, vol_reg};
            end
        end
    end

    assign aged = (now_reg - clear_time_reg) >= timeout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            clear_time_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                unique case (mode_reg)
                    prct_pkg::MODE_ADD:
                        if (!hit_reg && count_reg < CW'(DEPTH))
                            count_reg <= count_reg + 1'b1;
                    prct_pkg::MODE_CLEAR:
                    begin
                        count_reg <= '0; clear_time_reg <= now_reg;
                    end
                    prct_pkg::MODE_CLEAR_OLD:
                        if (aged)
                        begin
                            count_reg <= '0; clear_time_reg <= now_reg;
                        end
                    prct_pkg::MODE_REMOVE_NB:
                    begin
                        count_reg <= wr_reg; clear_time_reg <= now_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found_reg   <= 1'b0;
            idx_reg     <= '0;
            out_reg     <= '0;
            cleared_reg <= 1'b0;
            full_reg    <= 1'b0;
            unique case (mode_reg)
                prct_pkg::MODE_ADD:
                    if (hit_reg)
                    begin
                        found_reg <= 1'b1;
                        idx_reg   <= 4'({{(32-IW){1'b0}}, hit_idx_reg});
                        out_reg   <= '{hit_ent_reg.nb, hit_ent_reg.addr, hit_ent_reg.port,
                                       hit_ent_reg.hops, files_reg, vol_reg};
                    end
                    else if (count_reg < CW'(DEPTH))
                    begin
                        found_reg <= 1'b1;
                        idx_reg   <= 4'({{(32-CW){1'b0}}, count_reg});
                        out_reg   <= '{nb_reg, addr_reg, port_reg, hops_reg, files_reg, vol_reg};
                    end
                    else
                        full_reg <= 1'b1;
                prct_pkg::MODE_LOOKUP_HOPS, prct_pkg::MODE_LOOKUP_NB:
                    if (hit_reg)
                    begin
                        found_reg <= 1'b1;
                        idx_reg   <= 4'({{(32-IW){1'b0}}, hit_idx_reg});
                        out_reg   <= hit_ent_reg;
                    end
                prct_pkg::MODE_CLEAR_OLD:
                    cleared_reg <= aged;
                default: ;
            endcase
        end
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign entry_index   = idx_reg;
    assign out_neighbour = out_reg.nb;
    assign out_address   = out_reg.addr;
    assign out_port      = out_reg.port;
    assign out_hops      = out_reg.hops;
    assign out_files     = out_reg.files;
    assign out_volume    = out_reg.volume;
    assign cleared       = cleared_reg;
    assign table_full    = full_reg;

endmodule

>>> hw/rtl/peer_reply_cache_table_top.sv
// Peer reply cache table. Issue a command word with start while busy is low; the
// table walks its live entries one per cycle: add, lookups and remove-neighbour
// scan up to entry_count positions (a lookup or add match stops the scan early),
// while clear and clear-if-old do not scan. The result word is registered on the
// result ports and held until the next word finishes; done marks it for exactly one
// cycle, in which busy falls; the receiver cannot stall, so capture it on that cycle.
// Configure cache_timeout_ms at byte address 0 over the APB port while idle.
module peer_reply_cache_table_top
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [7:0]  neighbour_id,
    input  logic [31:0] address,
    input  logic [15:0] port,
    input  logic [7:0]  hops,
    input  logic [31:0] files,
    input  logic [31:0] volume,
    input  logic [15:0] ignore_mask,
    input  logic [31:0] now_ms,
    output logic        done,
    output logic        found,
    output logic [3:0]  entry_index,
    output logic [7:0]  out_neighbour,
    output logic [31:0] out_address,
    output logic [15:0] out_port,
    output logic [7:0]  out_hops,
    output logic [31:0] out_files,
    output logic [31:0] out_volume,
    output logic        cleared,
    output logic        table_full,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] timeout_reg;
    prct_pkg::cmd_t  cmd;
    prct_pkg::stat_t stat;

    // single register at address 0; other addresses ignore writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= prct_pkg::TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            timeout_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? timeout_reg : 32'd0;

    prct_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    prct_dp #(.DEPTH(TABLE_DEPTH)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .neighbour_id  (neighbour_id),
        .address       (address),
        .port          (port),
        .hops          (hops),
        .files         (files),
        .volume        (volume),
        .ignore_mask   (ignore_mask),
        .now_ms        (now_ms),
        .timeout       (timeout_reg),
        .done          (done),
        .found         (found),
        .entry_index   (entry_index),
        .out_neighbour (out_neighbour),
        .out_address   (out_address),
        .out_port      (out_port),
        .out_hops      (out_hops),
        .out_files     (out_files),
        .out_volume    (out_volume),
        .cleared       (cleared),
        .table_full    (table_full)
    );

endmodule
